@@ hw/rtl/tmlp_pkg.sv @@
package tmlp_pkg;

  localparam int unsigned MaxTagBytes = 64;
  localparam int unsigned TagIdxW     = (MaxTagBytes > 1) ? $clog2(MaxTagBytes) : 1;
  // counters run up to MaxTagBytes + 1
  localparam int unsigned TagCntW     = $clog2(MaxTagBytes + 2);

  localparam logic [TagCntW-1:0] TagMax = TagCntW'(MaxTagBytes);

  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutPtrW  = $clog2(OutDepth);
  localparam int unsigned OutCntW  = $clog2(OutDepth + 1);

  localparam logic [7:0] ChFormFeed = 8'h0C;
  localparam logic [7:0] ChNewline  = 8'h0A;
  localparam logic [7:0] ChTab      = 8'h09;
  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] ChLt       = 8'h3C;
  localparam logic [7:0] ChGt       = 8'h3E;
  localparam logic [7:0] ChStar     = 8'h2A;
  localparam logic [7:0] ChSlash    = 8'h2F;

  typedef enum logic [3:0] {
    PH_TOP,
    PH_OPEN,
    PH_STAG,
    PH_STXT0,
    PH_STXT,
    PH_MTAG0,
    PH_MTAG,
    PH_MBODY0,
    PH_MSKIP,
    PH_MLINE,
    PH_CLOSE0,
    PH_CLOSE1,
    PH_CNAME,
    PH_DONE,
    PH_ERR
  } phase_e;

  typedef enum logic [2:0] {
    K_TAG      = 3'd0,
    K_TXT      = 3'd1,
    K_TAGEND   = 3'd2,
    K_TXTEND   = 3'd3,
    K_DONE     = 3'd4,
    K_ERROR    = 3'd5,
    K_MISMATCH = 3'd6
  } kind_e;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == ChSpace) || (b == ChTab);
  endfunction

  function automatic logic is_delim(input logic [7:0] b);
    return (b == ChLt) || (b == ChGt) || (b == ChNewline) || (b == ChFormFeed);
  endfunction

  function automatic logic is_text_start(input logic [7:0] b);
    return !is_blank(b) && !is_delim(b) && (b != ChStar) && (b != ChSlash);
  endfunction

endpackage

@@ hw/rtl/tagged_markup_line_parser_core.sv @@
// Tagged markup line parser.
// Slave stream (s_*): one document byte per request in tdata[7:0]; byte 0x0C
// ends the document. Master stream (m_*): one result per request, kind code in
// tdata[2:0] (tag byte, text byte, tag end, text end, done, syntax error,
// tag mismatch).
// Each accepted byte is parsed in the cycle it is taken and gives zero, one or
// two results, which are queued in a four-entry output queue; the master side
// presents the head of that registered queue.
// Throughput: one byte per cycle while the receiver keeps up. The slave side
// takes a byte whenever the queue has room for two results, so a stalled
// receiver holds the sender off once three or more results are queued.
// The open tag of a multi-line entry is kept in a 64 x 8 RAM; the closing name
// is compared against it one byte per cycle while name bytes are accepted, with
// the read address running one byte ahead of the compare.
// Reset puts the parser at top level with an empty queue; the tag RAM is not
// cleared. After done or a syntax error, bytes are still accepted but dropped
// until reset.
module tagged_markup_line_parser_core
  import tmlp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  logic [7:0] s_tdata_i,   // [7:0] in_byte
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o    // [2:0] kind, [7:3] zero
);

  phase_e               phase_q, phase_d;
  logic [TagCntW-1:0]   len_q, len_d;
  logic [TagCntW-1:0]   cci_q, cci_d;
  logic                 mm_q, mm_d;
  logic                 ovf_q, ovf_d;

  kind_e                fifo_q [OutDepth];
  logic [OutPtrW-1:0]   wptr_q, rptr_q;
  logic [OutCntW-1:0]   cnt_q;

  logic                 in_acc, out_acc;
  logic [7:0]           b;
  logic [1:0]           n_res;
  kind_e                k0, k1;
  logic                 live;

  logic                 we;
  logic [7:0]           rdata;

  assign b          = s_tdata_i;
  assign s_tready_o = (cnt_q <= OutCntW'(OutDepth - 2));
  assign in_acc     = s_tvalid_i && s_tready_o;
  assign m_tvalid_o = (cnt_q != '0);
  assign out_acc    = m_tvalid_o && m_tready_i;
  assign m_tdata_o  = {5'b0, fifo_q[rptr_q]};

  tmlp_ram #(
    .Width (8),
    .Depth (MaxTagBytes)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (len_q[TagIdxW-1:0]),
    .wdata_i (b),
    .raddr_i (cci_d[TagIdxW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    cci_d   = cci_q;
    mm_d    = mm_q;
    ovf_d   = ovf_q;
    n_res   = 2'd0;
    k0      = K_ERROR;
    k1      = K_ERROR;
    live    = 1'b1;
    we      = 1'b0;

    if (in_acc) begin
      phase_d = PH_ERR;
      case (phase_q)
        PH_TOP: begin
          if (is_blank(b) || b == ChNewline) begin
            phase_d = PH_TOP;
          end else if (b == ChFormFeed) begin
            phase_d = PH_DONE;
            n_res = 2'd1; k0 = K_DONE;
          end else if (b == ChLt) begin
            phase_d = PH_OPEN;
          end
        end
        PH_OPEN: begin
          if (is_blank(b)) begin
            phase_d = PH_OPEN;
          end else if (b == ChStar) begin
            phase_d = PH_MTAG0;
            len_d   = '0;
            ovf_d   = 1'b0;
          end else if (is_text_start(b)) begin
            phase_d = PH_STAG;
            n_res = 2'd1; k0 = K_TAG;
          end
        end
        PH_STAG: begin
          if (b == ChGt) begin
            phase_d = PH_STXT0;
            n_res = 2'd1; k0 = K_TAGEND;
          end else if (!is_delim(b)) begin
            phase_d = PH_STAG;
            n_res = 2'd1; k0 = K_TAG;
          end
        end
        PH_STXT0: begin
          if (is_blank(b)) begin
            phase_d = PH_STXT0;
          end else if (is_text_start(b)) begin
            phase_d = PH_STXT;
            n_res = 2'd1; k0 = K_TXT;
          end
        end
        PH_STXT: begin
          if (b == ChNewline) begin
            phase_d = PH_TOP;
            n_res = 2'd1; k0 = K_TXTEND;
          end else if (!is_delim(b)) begin
            phase_d = PH_STXT;
            n_res = 2'd1; k0 = K_TXT;
          end
        end
        PH_MTAG0, PH_MTAG: begin
          if (phase_q == PH_MTAG && b == ChGt) begin
            phase_d = PH_MBODY0;
            n_res = 2'd1; k0 = K_TAGEND;
          end else if (phase_q == PH_MTAG0 && is_blank(b)) begin
            phase_d = PH_MTAG0;
          end else if ((phase_q == PH_MTAG0) ? is_text_start(b) : !is_delim(b)) begin
            phase_d = PH_MTAG;
            n_res = 2'd1; k0 = K_TAG;
            if (len_q < TagMax) begin
              we    = 1'b1;
              len_d = len_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
        PH_MBODY0, PH_MSKIP: begin
          if (is_blank(b) || b == ChNewline) begin
            phase_d = PH_MSKIP;
          end else if (phase_q == PH_MSKIP && b == ChLt) begin
            phase_d = PH_CLOSE0;
          end else if (is_text_start(b)) begin
            phase_d = PH_MLINE;
            n_res = 2'd1; k0 = K_TXT;
          end
        end
        PH_MLINE: begin
          if (b == ChNewline) begin
            phase_d = PH_MSKIP;
          end else if (!is_delim(b)) begin
            phase_d = PH_MLINE;
            n_res = 2'd1; k0 = K_TXT;
          end
        end
        PH_CLOSE0: begin
          if (is_blank(b)) begin
            phase_d = PH_CLOSE0;
          end else if (b == ChSlash) begin
            phase_d = PH_CLOSE1;
          end
        end
        PH_CLOSE1, PH_CNAME: begin
          if ((phase_q == PH_CLOSE1) ? is_text_start(b) : !is_delim(b)) begin
            phase_d = PH_CNAME;
            // cci is held at zero through the close phases, so the first
            // name byte compares against entry 0 already read out
            if (phase_q == PH_CLOSE1) begin
              mm_d = 1'b0;
            end
            if (cci_q < TagMax) begin
              if (cci_q >= len_q || rdata != b) begin
                mm_d = 1'b1;
              end
            end
            if (cci_q <= TagMax) begin
              cci_d = cci_q + 1'b1;
            end
          end else if (phase_q == PH_CLOSE1 && is_blank(b)) begin
            phase_d = PH_CLOSE1;
          end else if (phase_q == PH_CNAME) begin
            if (mm_q || ((cci_q > TagMax) != ovf_q) ||
                (!(cci_q > TagMax) && cci_q != len_q)) begin
              n_res = 2'd1; k0 = K_MISMATCH;
            end
            if (b == ChGt) begin
              phase_d = PH_TOP;
              if (n_res == 2'd0) begin
                n_res = 2'd1; k0 = K_TXTEND;
              end else begin
                n_res = 2'd2; k1 = K_TXTEND;
              end
            end
          end
        end
        default: begin
          // done or error: drop everything
          phase_d = phase_q;
          live    = 1'b0;
        end
      endcase

      if (live && phase_d == PH_ERR) begin
        if (n_res == 2'd0) begin
          n_res = 2'd1; k0 = K_ERROR;
        end else begin
          n_res = 2'd2; k1 = K_ERROR;
        end
      end
    end

    if (phase_d == PH_CLOSE0 || phase_d == PH_CLOSE1) begin
      cci_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TOP;
      len_q   <= '0;
      cci_q   <= '0;
      mm_q    <= 1'b0;
      ovf_q   <= 1'b0;
      wptr_q  <= '0;
      rptr_q  <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cci_q   <= cci_d;
      mm_q    <= mm_d;
      ovf_q   <= ovf_d;
      wptr_q  <= wptr_q + OutPtrW'(n_res);
      if (out_acc) begin
        rptr_q <= rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + OutCntW'(n_res) - OutCntW'(out_acc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) begin
      fifo_q[wptr_q] <= k0;
    end
    if (n_res == 2'd2) begin
      fifo_q[wptr_q + 1'b1] <= k1;
    end
  end

endmodule

@@ hw/rtl/tmlp_ram.sv @@
module tmlp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/tmlp_checker.sv @@
module tmlp_checker
  import tmlp_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_tvalid_i,
  input logic       s_tready_i,
  input logic [7:0] s_tdata_i,
  input logic       m_tvalid_i,
  input logic       m_tready_i,
  input logic [7:0] m_tdata_i
);

  logic out_acc;
  logic finished_q;
  logic after_mm_q;

  assign out_acc = m_tvalid_i && m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      finished_q <= 1'b0;
      after_mm_q <= 1'b0;
    end else if (out_acc) begin
      if (m_tdata_i[2:0] == K_DONE || m_tdata_i[2:0] == K_ERROR) begin
        finished_q <= 1'b1;
      end
      after_mm_q <= (m_tdata_i[2:0] == K_MISMATCH);
    end
  end

  // stalled request holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("result changed while stalled");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> m_tdata_i[7:3] == 5'd0 && m_tdata_i[2:0] != 3'd7)
    else $error("bad result code");

  a_nothing_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |-> !m_tvalid_i)
    else $error("result after done or error");

  a_mismatch_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && after_mm_q |->
      m_tdata_i[2:0] == K_TXTEND || m_tdata_i[2:0] == K_ERROR)
    else $error("mismatch not followed by text end or error");

  // '<' gives nothing, an error, or a mismatch ahead of an error inside a closing name
  a_lt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_tvalid_i && s_tvalid_i && s_tready_i && s_tdata_i == ChLt |=>
      !m_tvalid_i || m_tdata_i[2:0] == K_ERROR || m_tdata_i[2:0] == K_MISMATCH)
    else $error("unexpected result for '<'");

endmodule

bind tagged_markup_line_parser_core tmlp_checker u_tmlp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_i (s_tready_o),
  .s_tdata_i  (s_tdata_i),
  .m_tvalid_i (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_i  (m_tdata_o)
);
